### rtl/bayer_bilinear_demosaic_assert.svh
// Assertion macros for the bilinear demosaic checker.
// Needs nothing; included by the checker file.
`ifndef BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBD_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bbd_pkg.sv
// Shared types and constants of the bilinear Bayer demosaic.
// No dependencies; imported by every module of the block.
package bbd_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_REG_W      = 13;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int MIN_SIZE       = 2;

  localparam logic [CFG_REG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  // input op code for a pad transaction
  localparam logic OP_PAD = 1'b1;

  // divide by three: (x * 683) >> 11 is exact for x below 2046
  localparam int RECIP3       = 683;
  localparam int RECIP3_SHIFT = 11;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] raw_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } out_item_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture sample, read line store
    logic commit;    // write line store, shift window
    logic emit;      // commit produces an output pixel
    logic zero_pix;  // sample counts as zero (pad or tail)
    logic hl;        // left neighbor inside frame
    logic hr;        // right neighbor inside frame
    logic vu;        // upper neighbor inside frame
    logic vd;        // lower neighbor inside frame
    logic odd_row;
    logic odd_col;
    logic last;      // last pixel of the frame
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register can take a pixel this cycle
  } dp_status_t;

endpackage

### rtl/bayer_bilinear_demosaic.sv
// Bilinear Bayer demosaic for a GBRG raster stream. Each transaction has an
// accept cycle (S_IDLE) that reads the line store (MAX_WIDTH words of two
// samples, one registered read port) and an S_EXEC state that writes it
// back, shifts the 3x3 window and loads the output register; S_EXEC holds
// while the output register is full and stalled, and no new item is taken
// until the last one has committed. The RGB pixel for a site comes out
// frame_width+1 items after its raw sample; frame_width+1 pad items after
// the last sample flush the tail, and the frame wraps after the item that
// yields the last pixel (frame_end). Writing either size register restarts
// the frame. Sizes outside 2..MAX act as the nearest limit. No clearing
// pass is needed after reset: stale line store words never reach a mean.
// Depends on bbd_pkg, bbd_ctrl, bbd_datapath.
module bayer_bilinear_demosaic #(
  parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bbd_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bbd_pkg::out_item_t               out_data,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bbd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import bbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [CW-1:0] cmd_addr;

  bbd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_data.op),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cmd         (cmd),
    .cmd_addr    (cmd_addr),
    .status      (status)
  );

  bbd_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cmd_addr     (cmd_addr),
    .in_raw_pixel (in_data.raw_pixel),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

### rtl/bbd_ctrl.sv
// Controller of the bilinear demosaic: config registers, raster counters, FSM.
// Depends on bbd_pkg; drives bbd_datapath through dp_cmd_t.
module bbd_ctrl #(
  parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bbd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output bbd_pkg::dp_cmd_t                 cmd,
  output logic [CW-1:0]                    cmd_addr,
  input  bbd_pkg::dp_status_t              status
);
  import bbd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [CFG_REG_W-1:0] frame_width_r;
  logic [CFG_REG_W-1:0] frame_height_r;
  logic [WW-1:0]        w_eff;
  logic [HW-1:0]        h_eff;
  logic [CW-1:0]        w_last;
  logic [RW-1:0]        h_ext;
  logic [RW-1:0]        h_last;
  logic [CW-1:0]        col_r;
  logic [CW-1:0]        col_nxt;
  logic [RW-1:0]        row_r;
  logic [RW-1:0]        row_nxt;
  logic [CW-1:0]        ocol;
  logic [RW-1:0]        orow;
  fsm_state_t           state_r;
  fsm_state_t           state_nxt;
  cfg_reg_t             cfg_idx;
  logic                 cfg_wr;
  logic                 load;
  logic                 emit_a;
  logic                 emit_b;
  logic                 emit;
  logic                 commit;

  // register file
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_pwdata[CFG_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_pwdata[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = CFG_DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = CFG_DATA_W'(frame_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // frame size clamped to [2, MAX]
  always_comb begin
    if (frame_width_r < CFG_REG_W'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r < CFG_REG_W'(MIN_SIZE)) begin
      h_eff = HW'(MIN_SIZE);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  assign w_last = CW'(w_eff - WW'(1));
  assign h_ext  = RW'(h_eff);
  assign h_last = RW'(h_eff - HW'(1));

  // output position: column 0 finishes the previous row, else one behind
  assign emit_a = (col_r == '0) && (row_r >= RW'(2));
  assign emit_b = (col_r != '0) && (row_r != '0) && (row_r <= h_ext);
  assign emit   = emit_a || emit_b;
  assign orow   = emit_a ? row_r - RW'(2) : row_r - RW'(1);
  assign ocol   = emit_a ? w_last : col_r - CW'(1);
  assign commit = (state_r == S_EXEC) && (!emit || status.out_free);

  always_comb begin
    cmd.load     = load;
    cmd.commit   = commit;
    cmd.emit     = emit;
    cmd.zero_pix = (in_op == OP_PAD) || (row_r >= h_ext);
    cmd.hl       = (ocol != '0);
    cmd.hr       = (ocol != w_last);
    cmd.vu       = (orow != '0);
    cmd.vd       = (orow != h_last);
    cmd.odd_row  = orow[0];
    cmd.odd_col  = ocol[0];
    cmd.last     = (orow == h_last) && (ocol == w_last);
  end

  assign cmd_addr = col_r;

  // raster counters; a config write restarts the frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (commit) begin
      if ((col_r == '0) && (row_r == h_ext + RW'(1))) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == w_last) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state: accept, then execute until the commit (held while output is blocked)
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    load      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          load      = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### rtl/bbd_datapath.sv
// Datapath of the bilinear demosaic: line store, 3x3 window, means, output register.
// Depends on bbd_pkg; commanded by bbd_ctrl.
module bbd_datapath #(
  parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbd_pkg::dp_cmd_t            cmd,
  input  logic [CW-1:0]               cmd_addr,
  input  logic [bbd_pkg::PIX_W-1:0]   in_raw_pixel,
  output bbd_pkg::dp_status_t         status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bbd_pkg::out_item_t          out_data
);
  import bbd_pkg::*;

  localparam int LW = 2 * PIX_W;  // {two rows up, one row up}
  localparam int SW = PIX_W + 2;  // sum of up to four samples

  logic [LW-1:0]    line_mem [MAX_WIDTH];
  logic [LW-1:0]    line_rd_r;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] win_r   [3][3];
  logic [PIX_W-1:0] win_nxt [3][3];
  logic [SW-1:0]    hsum;
  logic [SW-1:0]    vsum;
  logic [SW-1:0]    dsum;
  logic [2:0]       hcnt;
  logic [2:0]       vcnt;
  logic [2:0]       dcnt;
  logic [PIX_W-1:0] hmean;
  logic [PIX_W-1:0] vmean;
  logic [PIX_W-1:0] xmean;
  logic [PIX_W-1:0] dmean;
  out_item_t        result;
  out_item_t        out_data_r;
  logic             out_valid_r;

  // truncated mean of one to four samples
  function automatic logic [PIX_W-1:0] mean_of(input logic [SW-1:0] sum,
                                               input logic [2:0] cnt);
    logic [SW+9:0] prod;
    prod = (SW+10)'(sum) * (SW+10)'(RECIP3);
    case (cnt)
      3'd1:    mean_of = sum[PIX_W-1:0];
      3'd2:    mean_of = sum[PIX_W:1];
      3'd3:    mean_of = prod[RECIP3_SHIFT +: PIX_W];
      3'd4:    mean_of = sum[PIX_W+1:2];
      default: mean_of = '0;
    endcase
  endfunction

  // line store: read on accept, write back on commit at the same column
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_rd_r <= line_mem[cmd_addr];
    end
    if (cmd.commit) begin
      line_mem[cmd_addr] <= {line_rd_r[PIX_W-1:0], pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= cmd.zero_pix ? '0 : in_raw_pixel;
    end
  end

  // window after the shift, new column on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = line_rd_r[LW-1:PIX_W];
    win_nxt[1][2] = line_rd_r[PIX_W-1:0];
    win_nxt[2][2] = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else if (cmd.commit) begin
      win_r <= win_nxt;
    end
  end

  // neighbor sums over in-frame samples
  always_comb begin
    hsum = (cmd.hl ? SW'(win_nxt[1][0]) : '0) + (cmd.hr ? SW'(win_nxt[1][2]) : '0);
    vsum = (cmd.vu ? SW'(win_nxt[0][1]) : '0) + (cmd.vd ? SW'(win_nxt[2][1]) : '0);
    dsum = ((cmd.vu && cmd.hl) ? SW'(win_nxt[0][0]) : '0)
         + ((cmd.vu && cmd.hr) ? SW'(win_nxt[0][2]) : '0)
         + ((cmd.vd && cmd.hl) ? SW'(win_nxt[2][0]) : '0)
         + ((cmd.vd && cmd.hr) ? SW'(win_nxt[2][2]) : '0);
    hcnt = 3'(cmd.hl) + 3'(cmd.hr);
    vcnt = 3'(cmd.vu) + 3'(cmd.vd);
    dcnt = 3'(cmd.vu && cmd.hl) + 3'(cmd.vu && cmd.hr)
         + 3'(cmd.vd && cmd.hl) + 3'(cmd.vd && cmd.hr);
    hmean = mean_of(hsum, hcnt);
    vmean = mean_of(vsum, vcnt);
    xmean = mean_of(hsum + vsum, hcnt + vcnt);
    dmean = mean_of(dsum, dcnt);
  end

  // channel select by site: GBRG, even rows G B, odd rows R G
  always_comb begin
    result.frame_end = cmd.last;
    if (cmd.odd_row == cmd.odd_col) begin
      result.green = win_nxt[1][1];
      if (cmd.odd_row) begin
        result.red  = hmean;
        result.blue = vmean;
      end else begin
        result.blue = hmean;
        result.red  = vmean;
      end
    end else if (cmd.odd_row) begin
      result.red   = win_nxt[1][1];
      result.green = xmean;
      result.blue  = dmean;
    end else begin
      result.blue  = win_nxt[1][1];
      result.green = xmean;
      result.red   = dmean;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.emit) begin
      out_data_r <= result;
    end
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

### rtl/bbd_checker.sv
// Port-level assertions for the bilinear demosaic, bound to the top level.
// Depends on bbd_pkg and bayer_bilinear_demosaic_assert.svh.
`include "bayer_bilinear_demosaic_assert.svh"

module bbd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input bbd_pkg::out_item_t               out_data,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic [bbd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  input logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_prdata
);
  import bbd_pkg::*;

  // a stalled result holds
  `BBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "output transaction changed while stalled")

  // one transaction in flight: the input stalls right after an accept
  `BBD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "input accepted while a transaction is in flight")

  // a fresh result traces back to an accepted input transaction
  `BBD_ASSERT_NOW(a_out_origin, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "output appeared without a matching input transaction")

  // a register write reads back at the same address
  `BBD_ASSERT_NEXT(a_cfg_readback, clk, rst_n, cfg_psel && cfg_penable && cfg_pwrite, (cfg_paddr[2] != $past(cfg_paddr[2])) || (cfg_prdata[CFG_REG_W-1:0] == $past(cfg_pwdata[CFG_REG_W-1:0])), "register readback mismatch")

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (.*);
